// ===== rtl/mcd_pkg.sv =====
`timescale 1ns / 1ps
package mcd_pkg;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int KSIZE = 5;
	localparam int PIX_W = 8;
	localparam int DIM_W = 11;
	localparam int COL_W = 13;
	localparam int ROW_W = 12;
	localparam int TOK_W = COL_W + 3;
	localparam int THR_W = 8;
	localparam int IDX_W = 2;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = 3;

	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RST = 11'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	localparam logic [0:KSIZE-1][0:KSIZE-1] SE_CROSS =
		{5'b00100, 5'b00100, 5'b11111, 5'b00100, 5'b00100};
	localparam logic [0:KSIZE-1][0:KSIZE-1] SE_DIAMOND =
		{5'b00100, 5'b01110, 5'b11111, 5'b01110, 5'b00100};
	localparam logic [0:KSIZE-1][0:KSIZE-1] SE_X =
		{5'b10001, 5'b01010, 5'b00100, 5'b01010, 5'b10001};
	localparam logic [0:KSIZE-1][0:KSIZE-1] SE_SQUARE =
		{5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111};

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] qcol;
		logic             dil_on;
		logic             out_on;
		logic             eor;
		logic             eof;
		logic [KSIZE-1:0] drow_ok;
		logic [KSIZE-1:0] dcol_ok;
		logic [KSIZE-1:0] erow_ok;
		logic [KSIZE-1:0] ecol_ok;
	} tok_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             eor;
		logic             eof;
	} res_t;
endpackage

// ===== rtl/morph_corner_detector_unit.sv =====
`timescale 1ns / 1ps
// Morphological corner detector, 5x5 windows, 8-bit grey pixels in raster order.
// s_axis: tuser = operation (0 pixel, 1 flush), tdata = pixel; one per clock if tready.
// m_axis: tdata = corner value, tlast = end of row, tuser = end of frame.
// cfg: cfg_we writes register cfg_index (0 threshold, 1 width, 2 height); writing
// width or height restarts the frame. Write only while the block is idle.
// A frame takes W*H pixels then 4*W+4 further transactions (flush ticks) to drain;
// output pixel k is produced by input transaction k+4*W+4. Flushes that arrive
// before the last pixel of a frame are consumed without effect.
// Throughput is one transaction per cycle while s_axis_tready is high; the path
// from the causing input transaction to m_axis_tvalid is registered at line store
// read, dilation window, window maximum, second line store read, erosion window,
// row minima, then final minimum and difference into the FIFO.
// The line stores are single-port-write, registered-read RAMs, one word per column.
// Reset clears all counters and the output FIFO; no clearing pass of the line stores.
// When the receiver stalls, results collect in an 8-entry FIFO; s_axis_tready
// drops once queued plus in-flight results would fill it.
module morph_corner_detector_unit import mcd_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // [7:0] pixel
	input  logic             s_axis_tuser,   // [0] operation
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] corner_value
	output logic             m_axis_tlast,
	output logic             m_axis_tuser,   // [0] end_of_frame
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata
);
	logic             accept, tok_valid, d_valid, push, pop;
	tok_t             tok, d_tok;
	logic [PIX_W-1:0] d_a, d_b;
	logic [THR_W-1:0] threshold;
	res_t             res;
	res_t             fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q, pend_q;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = ({1'b0, cnt_q} + {1'b0, pend_q}) < (FIFO_AW + 2)'(FIFO_DEPTH);

	mcd_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.op        (s_axis_tuser),
		.pixel     (s_axis_tdata),
		.tok_valid (tok_valid),
		.tok       (tok),
		.threshold (threshold)
	);

	mcd_dilate #(.MAX_WIDTH(MAX_WIDTH)) u_dilate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tok_valid),
		.in_tok    (tok),
		.out_valid (d_valid),
		.out_tok   (d_tok),
		.out_a     (d_a),
		.out_b     (d_b)
	);

	mcd_erode #(.MAX_WIDTH(MAX_WIDTH)) u_erode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_tok    (d_tok),
		.in_a      (d_a),
		.in_b      (d_b),
		.threshold (threshold),
		.push      (push),
		.res       (res)
	);

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = fifo_q[rd_ptr_q].value;
	assign m_axis_tlast  = fifo_q[rd_ptr_q].eor;
	assign m_axis_tuser  = fifo_q[rd_ptr_q].eof;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			pend_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			cnt_q  <= cnt_q + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
			pend_q <= pend_q + (FIFO_AW + 1)'(tok_valid && tok.out_on)
				- (FIFO_AW + 1)'(push);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end
endmodule

// ===== rtl/mcd_ram.sv =====
`timescale 1ns / 1ps
module mcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/mcd_ctrl.sv =====
`timescale 1ns / 1ps
module mcd_ctrl import mcd_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata,
	input  logic             accept,
	input  logic             op,
	input  logic [PIX_W-1:0] pixel,
	output logic             tok_valid,
	output tok_t             tok,
	output logic [THR_W-1:0] threshold
);
	logic [THR_W-1:0] thr_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic [COL_W-1:0] in_col_q, q_col_q, o_col_q;
	logic [ROW_W-1:0] in_row_q, q_row_q, o_row_q;
	logic [TOK_W-1:0] tok_cnt_q;

	logic [COL_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [TOK_W-1:0] dil_start, out_start;
	logic             draining, dil_on, out_on, eor, eof;

	always_comb begin
		if (width_q == '0) begin
			w_eff = COL_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = COL_W'(MAX_WIDTH);
		end else begin
			w_eff = COL_W'(width_q);
		end
		h_eff = (height_q == '0) ? ROW_W'(1) : ROW_W'(height_q);
	end

	assign dil_start = (TOK_W'(w_eff) << 1) + TOK_W'(2);
	assign out_start = (TOK_W'(w_eff) << 2) + TOK_W'(4);
	assign draining  = in_row_q >= h_eff;
	assign dil_on    = tok_cnt_q >= dil_start;
	assign out_on    = tok_cnt_q >= out_start;
	assign eor       = o_col_q == w_eff - COL_W'(1);
	assign eof       = eor && (o_row_q == h_eff - ROW_W'(1));
	assign tok_valid = accept && (!op || draining);
	assign threshold = thr_q;

	always_comb begin
		int r, c;
		tok         = '0;
		tok.col     = in_col_q;
		tok.pixel   = pixel;
		tok.qcol    = q_col_q;
		tok.dil_on  = dil_on;
		tok.out_on  = out_on;
		tok.eor     = eor;
		tok.eof     = eof;
		for (int k = 0; k < KSIZE; k++) begin
			r = int'(q_row_q) + k - 2;
			c = int'(q_col_q) + k - 2;
			tok.drow_ok[k] = (r >= 0) && (r < int'(h_eff));
			tok.dcol_ok[k] = (c >= 0) && (c < int'(w_eff));
			r = int'(o_row_q) + k - 2;
			c = int'(o_col_q) + k - 2;
			tok.erow_ok[k] = (r >= 0) && (r < int'(h_eff));
			tok.ecol_ok[k] = (c >= 0) && (c < int'(w_eff));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			in_col_q  <= '0;
			in_row_q  <= '0;
			q_col_q   <= '0;
			q_row_q   <= '0;
			o_col_q   <= '0;
			o_row_q   <= '0;
			tok_cnt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
				REG_WIDTH, REG_HEIGHT: begin
					if (cfg_index == REG_WIDTH) begin
						width_q <= cfg_wdata;
					end else begin
						height_q <= cfg_wdata;
					end
					in_col_q  <= '0;
					in_row_q  <= '0;
					q_col_q   <= '0;
					q_row_q   <= '0;
					o_col_q   <= '0;
					o_row_q   <= '0;
					tok_cnt_q <= '0;
				end
				default: ;
			endcase
		end else if (tok_valid) begin
			if (out_on && eof) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				q_col_q   <= '0;
				q_row_q   <= '0;
				o_col_q   <= '0;
				o_row_q   <= '0;
				tok_cnt_q <= '0;
			end else begin
				if (in_col_q == w_eff - COL_W'(1)) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (!out_on) begin
					tok_cnt_q <= tok_cnt_q + TOK_W'(1);
				end
				if (dil_on) begin
					if (q_col_q == w_eff - COL_W'(1)) begin
						q_col_q <= '0;
						q_row_q <= q_row_q + ROW_W'(1);
					end else begin
						q_col_q <= q_col_q + COL_W'(1);
					end
				end
				if (out_on) begin
					if (eor) begin
						o_col_q <= '0;
						o_row_q <= o_row_q + ROW_W'(1);
					end else begin
						o_col_q <= o_col_q + COL_W'(1);
					end
				end
			end
		end
	end
endmodule

// ===== rtl/mcd_dilate.sv =====
`timescale 1ns / 1ps
module mcd_dilate import mcd_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  tok_t             in_tok,
	output logic             out_valid,
	output tok_t             out_tok,
	output logic [PIX_W-1:0] out_a,
	output logic [PIX_W-1:0] out_b
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WORD_W = (KSIZE - 1) * PIX_W;

	logic              v_s1, v_s2, v_s3;
	tok_t              tok_s1, tok_s2, tok_s3;
	logic              hit_s1;
	logic [WORD_W-1:0] fwd_s1, ram_q, rd_s1, wdata_s1;
	logic [PIX_W-1:0]  win_q [KSIZE][KSIZE];
	logic [PIX_W-1:0]  col_s1 [KSIZE];
	logic [PIX_W-1:0]  max_a, max_b, a_s3, b_s3;

	mcd_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (v_s1),
		.waddr (tok_s1.col[AW-1:0]),
		.wdata (wdata_s1),
		.re    (in_valid),
		.raddr (in_tok.col[AW-1:0]),
		.rdata (ram_q)
	);

	assign rd_s1    = hit_s1 ? fwd_s1 : ram_q;
	assign wdata_s1 = {tok_s1.pixel, rd_s1[WORD_W-1:PIX_W]};

	always_comb begin
		for (int k = 0; k < KSIZE - 1; k++) begin
			col_s1[k] = rd_s1[k*PIX_W +: PIX_W];
		end
		col_s1[KSIZE-1] = tok_s1.pixel;
	end

	// out-of-image taps drop out of the maximum
	always_comb begin
		max_a = '0;
		max_b = '0;
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				if (tok_s2.drow_ok[i] && tok_s2.dcol_ok[j]) begin
					if (SE_CROSS[i][j] && win_q[i][j] > max_a) begin
						max_a = win_q[i][j];
					end
					if (SE_X[i][j] && win_q[i][j] > max_b) begin
						max_b = win_q[i][j];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= in_tok;
		hit_s1 <= v_s1 && (tok_s1.col == in_tok.col);
		fwd_s1 <= wdata_s1;
		tok_s2 <= tok_s1;
		tok_s3 <= tok_s2;
		a_s3   <= max_a;
		b_s3   <= max_b;
		if (v_s1) begin
			for (int i = 0; i < KSIZE; i++) begin
				for (int j = 0; j < KSIZE - 1; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
				win_q[i][KSIZE-1] <= col_s1[i];
			end
		end
	end

	assign out_valid = v_s3;
	assign out_tok   = tok_s3;
	assign out_a     = a_s3;
	assign out_b     = b_s3;
endmodule

// ===== rtl/mcd_erode.sv =====
`timescale 1ns / 1ps
module mcd_erode import mcd_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  tok_t             in_tok,
	input  logic [PIX_W-1:0] in_a,
	input  logic [PIX_W-1:0] in_b,
	input  logic [THR_W-1:0] threshold,
	output logic             push,
	output res_t             res
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PAIR_W = 2 * PIX_W;
	localparam int WORD_W = (KSIZE - 1) * PAIR_W;

	logic              rd_e0, v_e1, v_e2, v_e3;
	tok_t              tok_e1, tok_e2, tok_e3;
	logic [PAIR_W-1:0] pair_e1;
	logic              hit_e1;
	logic [WORD_W-1:0] fwd_e1, ram_q, rd_e1, wdata_e1;
	logic [PAIR_W-1:0] win_q [KSIZE][KSIZE];
	logic [PAIR_W-1:0] col_e1 [KSIZE];
	logic [PIX_W-1:0]  rmin_a [KSIZE];
	logic [PIX_W-1:0]  rmin_b [KSIZE];
	logic [PIX_W-1:0]  rmin_a_e3 [KSIZE];
	logic [PIX_W-1:0]  rmin_b_e3 [KSIZE];
	logic [PIX_W-1:0]  ero_a, ero_b, diff;

	assign rd_e0 = in_valid && in_tok.dil_on;

	mcd_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (v_e1),
		.waddr (tok_e1.qcol[AW-1:0]),
		.wdata (wdata_e1),
		.re    (rd_e0),
		.raddr (in_tok.qcol[AW-1:0]),
		.rdata (ram_q)
	);

	assign rd_e1    = hit_e1 ? fwd_e1 : ram_q;
	assign wdata_e1 = {pair_e1, rd_e1[WORD_W-1:PAIR_W]};

	always_comb begin
		for (int k = 0; k < KSIZE - 1; k++) begin
			col_e1[k] = rd_e1[k*PAIR_W +: PAIR_W];
		end
		col_e1[KSIZE-1] = pair_e1;
	end

	// per-row minima; pair holds {branch a, branch b}
	always_comb begin
		for (int i = 0; i < KSIZE; i++) begin
			rmin_a[i] = PIX_MAX;
			rmin_b[i] = PIX_MAX;
			for (int j = 0; j < KSIZE; j++) begin
				if (tok_e2.erow_ok[i] && tok_e2.ecol_ok[j]) begin
					if (SE_DIAMOND[i][j] && win_q[i][j][PAIR_W-1:PIX_W] < rmin_a[i]) begin
						rmin_a[i] = win_q[i][j][PAIR_W-1:PIX_W];
					end
					if (SE_SQUARE[i][j] && win_q[i][j][PIX_W-1:0] < rmin_b[i]) begin
						rmin_b[i] = win_q[i][j][PIX_W-1:0];
					end
				end
			end
		end
	end

	always_comb begin
		ero_a = PIX_MAX;
		ero_b = PIX_MAX;
		for (int i = 0; i < KSIZE; i++) begin
			if (rmin_a_e3[i] < ero_a) begin
				ero_a = rmin_a_e3[i];
			end
			if (rmin_b_e3[i] < ero_b) begin
				ero_b = rmin_b_e3[i];
			end
		end
		diff = (ero_a > ero_b) ? ero_a - ero_b : ero_b - ero_a;
		res.value = diff;
		if (threshold != '0) begin
			res.value = (diff > threshold) ? PIX_MAX : '0;
		end
		res.eor = tok_e3.eor;
		res.eof = tok_e3.eof;
	end

	assign push = v_e3 && tok_e3.out_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
			v_e3 <= 1'b0;
		end else begin
			v_e1 <= rd_e0;
			v_e2 <= v_e1;
			v_e3 <= v_e2;
		end
	end

	always_ff @(posedge clk) begin
		tok_e1  <= in_tok;
		pair_e1 <= {in_a, in_b};
		hit_e1  <= v_e1 && (tok_e1.qcol == in_tok.qcol);
		fwd_e1  <= wdata_e1;
		tok_e2  <= tok_e1;
		tok_e3  <= tok_e2;
		for (int i = 0; i < KSIZE; i++) begin
			rmin_a_e3[i] <= rmin_a[i];
			rmin_b_e3[i] <= rmin_b[i];
		end
		if (v_e1) begin
			for (int i = 0; i < KSIZE; i++) begin
				for (int j = 0; j < KSIZE - 1; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
				win_q[i][KSIZE-1] <= col_e1[i];
			end
		end
	end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import mcd_pkg::*;

	localparam int WD_LIMIT = 20000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = '0;
	logic             s_axis_tuser = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;
	logic             m_axis_tlast;
	logic             m_axis_tuser;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_wdata = '0;

	morph_corner_detector_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// pending pixel/flush transactions: {operation, pixel}
	logic [8:0] pixel_q[$];
	res_t       corner_q[$];
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;
	bit         src_hold = 1'b0;
	int         mismatches = 0;
	bit         failed = 1'b0;
	int         quiet_cycles = 0;

	// shadow of the block's registers and frame position
	logic [THR_W-1:0] p_thr = '0;
	logic [DIM_W-1:0] p_w = WIDTH_RST;
	logic [DIM_W-1:0] p_h = HEIGHT_RST;
	int unsigned in_col, in_row, out_col, out_row, adv_count;
	logic [7:0] ring_mem [0:16*1024-1];

	function automatic int eff_width();
		if (p_w == 0) return 1;
		if (p_w > 1024) return 1024;
		return int'(p_w);
	endfunction

	function automatic int eff_height();
		return (p_h == 0) ? 1 : int'(p_h);
	endfunction

	function automatic int win_max(logic [0:KSIZE-1][0:KSIZE-1] se, int r, int c, int w, int h);
		int best;
		int rr;
		int cc;
		best = 0;
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++) begin
				rr = r + i - 2;
				cc = c + j - 2;
				if (se[i][j] && rr >= 0 && rr < h && cc >= 0 && cc < w)
					if (ring_mem[(rr & 15) * 1024 + cc] > best)
						best = ring_mem[(rr & 15) * 1024 + cc];
			end
		return best;
	endfunction

	function automatic int dil_then_erode(logic [0:KSIZE-1][0:KSIZE-1] sd,
			logic [0:KSIZE-1][0:KSIZE-1] se, int r, int c, int w, int h);
		int best;
		int rr;
		int cc;
		int v;
		best = 255;
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++) begin
				rr = r + i - 2;
				cc = c + j - 2;
				if (se[i][j] && rr >= 0 && rr < h && cc >= 0 && cc < w) begin
					v = win_max(sd, rr, cc, w, h);
					if (v < best) best = v;
				end
			end
		return best;
	endfunction

	task automatic predict_corner(logic [8:0] item);
		int w;
		int h;
		int a;
		int b;
		int d;
		res_t res;
		w = eff_width();
		h = eff_height();
		if (in_row < h) begin
			if (item[8]) return;
			ring_mem[(in_row & 15) * 1024 + in_col] = item[7:0];
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		adv_count++;
		if (adv_count <= 4 * (w + 1)) return;
		a = dil_then_erode(SE_CROSS, SE_DIAMOND, out_row, out_col, w, h);
		b = dil_then_erode(SE_X, SE_SQUARE, out_row, out_col, w, h);
		d = (a > b) ? a - b : b - a;
		if (p_thr != 0) d = (d > p_thr) ? 255 : 0;
		res.value = d[7:0];
		res.eor = (out_col == w - 1);
		res.eof = res.eor && (out_row == h - 1);
		corner_q.push_back(res);
		if (res.eof) begin
			in_col = 0; in_row = 0; out_col = 0; out_row = 0; adv_count = 0;
		end else if (res.eor) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_corner({s_axis_tuser, s_axis_tdata});
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pixel_q.size() > 0 && !src_hold &&
						$urandom_range(99) >= src_idle_pct) begin
					logic [8:0] nxt;
					nxt = pixel_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= nxt[8];
					s_axis_tdata <= nxt[7:0];
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (corner_q.size() == 0) begin
					failed = 1'b1;
					if (mismatches < 10)
						$display("unexpected result value=%0d eor=%0b eof=%0b",
							m_axis_tdata, m_axis_tlast, m_axis_tuser);
					mismatches++;
				end else begin
					res_t e;
					e = corner_q.pop_front();
					if (e.value !== m_axis_tdata || e.eor !== m_axis_tlast ||
							e.eof !== m_axis_tuser) begin
						failed = 1'b1;
						if (mismatches < 10)
							$display("mismatch exp v=%0d eor=%0b eof=%0b got v=%0d eor=%0b eof=%0b",
								e.value, e.eor, e.eof, m_axis_tdata, m_axis_tlast,
								m_axis_tuser);
						mismatches++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(pixel_q.size() == 0 && !s_axis_tvalid && corner_q.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_THRESHOLD) begin
			p_thr = val[7:0];
		end else if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
			if (idx == REG_WIDTH) p_w = val; else p_h = val;
			in_col = 0; in_row = 0; out_col = 0; out_row = 0; adv_count = 0;
		end
	endtask

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic queue_frame();
		int w;
		int h;
		w = eff_width();
		h = eff_height();
		for (int k = 0; k < w * h; k++) begin
			if ($urandom_range(9) == 0) pixel_q.push_back({1'b1, 8'($urandom())});
			pixel_q.push_back({1'b0, rand_pixel()});
		end
		for (int k = 0; k < 4 * (w + 1); k++)
			pixel_q.push_back({($urandom_range(7) != 0), 8'($urandom())});
	endtask

	task automatic drain_wait();
		while (pixel_q.size() > 0 || s_axis_tvalid || corner_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic run_phase(int ph, int thr, int w, int h, int frames);
		src_idle_pct = (ph % 4 == 1) ? 82 : (ph % 4 == 3) ? 20 : 0;
		sink_stall_pct = (ph % 4 == 2) ? 82 : (ph % 4 == 3) ? 20 : 0;
		write_reg(REG_THRESHOLD, DIM_W'(thr));
		write_reg(REG_WIDTH, DIM_W'(w));
		write_reg(REG_HEIGHT, DIM_W'(h));
		for (int f = 0; f < frames; f++) queue_frame();
		drain_wait();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 1x1 frames, early flush, extremes, pixel during drain
		write_reg(REG_THRESHOLD, DIM_W'(0));
		write_reg(REG_WIDTH, DIM_W'(1));
		write_reg(REG_HEIGHT, DIM_W'(1));
		write_reg(2'd3, 11'h7FF);
		pixel_q.push_back({1'b1, 8'hFF});
		pixel_q.push_back({1'b0, 8'hFF});
		for (int k = 0; k < 8; k++) pixel_q.push_back({(k != 3), 8'h00});
		pixel_q.push_back({1'b0, 8'h00});
		for (int k = 0; k < 8; k++) pixel_q.push_back({1'b1, 8'hAA});
		drain_wait();

		run_phase(0, 0, 4, 4, 2);
		run_phase(1, 255, 3, 5, 2);
		run_phase(2, 1, 8, 3, 1);
		run_phase(3, 40, 5, 5, 1);
		run_phase(0, 0, 0, 0, 2);
		run_phase(1, 0, 1, 40, 1);
		run_phase(2, $urandom_range(255), 7, 2, 1);

		// sender pause mid-frame until every result is back
		src_idle_pct = 0;
		sink_stall_pct = 20;
		write_reg(REG_THRESHOLD, DIM_W'(0));
		write_reg(REG_WIDTH, DIM_W'(6));
		write_reg(REG_HEIGHT, DIM_W'(6));
		queue_frame();
		while (pixel_q.size() > 25) @(posedge clk);
		src_hold = 1'b1;
		while (corner_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		src_hold = 1'b0;
		drain_wait();

		run_phase(3, $urandom_range(1, 254), 6, 6, 1);
		run_phase(2, 128, 2, 9, 3);
		run_phase(3, 0, 16, 2, 1);

		drain_wait();
		repeat (30) @(posedge clk);
		if (corner_q.size() > 0) failed = 1'b1;
		if (!failed) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
